/* rtl/core/ctig_pkg.sv */
// Package for the circular trajectory IMU generator: constants, register
// indexes, CORDIC table and saturation helpers. No dependencies.
`timescale 1ns / 1ps

package ctig_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int CORDIC_STEPS    = 28;
  localparam int STEPS_PER_STAGE = 2;

  // 1/(2*pi) in Q0.32
  localparam logic [29:0] TURN_PER_RAD_Q32 = 30'd683565276;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam logic [31:0] RADIUS_RESET    = 32'd65536;
  localparam logic [31:0] GRAVITY_Z_RESET = 32'd642908;

  typedef enum logic [2:0] {
    REG_PHASE_START   = 3'd0,
    REG_HEADING_START = 3'd1,
    REG_TURN_RATE     = 3'd2,
    REG_RADIUS        = 3'd3,
    REG_GRAVITY_X     = 3'd4,
    REG_GRAVITY_Y     = 3'd5,
    REG_GRAVITY_Z     = 3'd6
  } cfg_reg_t;

  // arctan(2^-i) in binary turns
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5
  };

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [31:0] z;
  } rot_t;

  function automatic rot_t rot_step(input rot_t v, input logic [4:0] idx);
    rot_t r;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [31:0] a;
    dx = v.y >>> idx;
    dy = v.x >>> idx;
    a  = signed'(ATAN_TURNS[idx]);
    if (!v.z[31]) begin
      r.x = v.x - dx;
      r.y = v.y + dy;
      r.z = v.z - a;
    end else begin
      r.x = v.x + dx;
      r.y = v.y - dy;
      r.z = v.z + a;
    end
    return r;
  endfunction

  // saturate a sign/magnitude value to 32-bit two's complement
  function automatic logic [31:0] sat_mag(input logic [63:0] mag, input logic neg);
    logic [31:0] r;
    if (neg) begin
      if (mag > 64'd2147483648) r = 32'h8000_0000;
      else                      r = 32'd0 - mag[31:0];
    end else begin
      if (mag > 64'd2147483647) r = 32'h7fff_ffff;
      else                      r = mag[31:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_s37(input logic signed [36:0] v);
    logic [31:0] r;
    if (v > 37'sd2147483647)       r = 32'h7fff_ffff;
    else if (v < -37'sd2147483648) r = 32'h8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

endpackage

/* rtl/core/ctig_cordic.sv */
// Two-lane pipelined CORDIC: cos/sin in Q2.30 of two binary angles.
// Depends on ctig_pkg.
`timescale 1ns / 1ps

module ctig_cordic (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [31:0] in_theta,
  input  logic [31:0] in_yaw,
  output logic        out_vld,
  output logic [31:0] out_c,
  output logic [31:0] out_s,
  output logic [31:0] out_cy,
  output logic [31:0] out_sy,
  output logic [31:0] out_yaw
);

  localparam int NST = ctig_pkg::CORDIC_STEPS / ctig_pkg::STEPS_PER_STAGE;

  ctig_pkg::rot_t rot_r  [0:NST][0:1];
  logic [1:0]     quad_r [0:NST][0:1];
  logic [31:0]    yaw_r  [0:NST];
  logic [NST:0]   vld_r;
  logic [31:0]    ang    [0:1];
  logic [31:0]    c_nxt  [0:1];
  logic [31:0]    s_nxt  [0:1];
  logic           out_vld_r;
  logic [31:0]    c_r [0:1];
  logic [31:0]    s_r [0:1];
  logic [31:0]    yaw_out_r;

  assign ang[0] = in_theta;
  assign ang[1] = in_yaw;

  function automatic logic [31:0] clamp_unit(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd1073741824)       r = 32'h4000_0000;
    else if (v < -34'sd1073741824) r = 32'hc000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

  genvar l, k;
  generate
    for (l = 0; l < 2; l++) begin : g_lane
      logic [31:0] sh;
      assign sh = ang[l] + 32'h2000_0000;

      always_ff @(posedge clk) begin
        if (en) begin
          quad_r[0][l]  <= sh[31:30];
          rot_r[0][l].x <= ctig_pkg::CORDIC_GAIN_Q30;
          rot_r[0][l].y <= '0;
          rot_r[0][l].z <= signed'({2'b00, sh[29:0]}) - 32'sh2000_0000;
        end
      end

      for (k = 1; k <= NST; k++) begin : g_stage
        ctig_pkg::rot_t v_nxt;
        always_comb begin
          v_nxt = rot_r[k-1][l];
          for (int j = 0; j < ctig_pkg::STEPS_PER_STAGE; j++) begin
            v_nxt = ctig_pkg::rot_step(v_nxt,
                      5'((k - 1) * ctig_pkg::STEPS_PER_STAGE + j));
          end
        end
        always_ff @(posedge clk) begin
          if (en) begin
            rot_r[k][l]  <= v_nxt;
            quad_r[k][l] <= quad_r[k-1][l];
          end
        end
      end

      // quadrant fold back
      logic [31:0] xc, yc;
      always_comb begin
        xc = clamp_unit(rot_r[NST][l].x);
        yc = clamp_unit(rot_r[NST][l].y);
        case (quad_r[NST][l])
          2'd0: begin c_nxt[l] = xc;          s_nxt[l] = yc;          end
          2'd1: begin c_nxt[l] = 32'd0 - yc;  s_nxt[l] = xc;          end
          2'd2: begin c_nxt[l] = 32'd0 - xc;  s_nxt[l] = 32'd0 - yc;  end
          default: begin c_nxt[l] = yc;       s_nxt[l] = 32'd0 - xc;  end
        endcase
      end

      always_ff @(posedge clk) begin
        if (en) begin
          c_r[l] <= c_nxt[l];
          s_r[l] <= s_nxt[l];
        end
      end
    end

    for (k = 1; k <= NST; k++) begin : g_yaw
      always_ff @(posedge clk) begin
        if (en) yaw_r[k] <= yaw_r[k-1];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      yaw_r[0]  <= in_yaw;
      yaw_out_r <= yaw_r[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r     <= {vld_r[NST-1:0], in_vld};
      out_vld_r <= vld_r[NST];
    end
  end

  assign out_vld = out_vld_r;
  assign out_c   = c_r[0];
  assign out_s   = s_r[0];
  assign out_cy  = c_r[1];
  assign out_sy  = s_r[1];
  assign out_yaw = yaw_out_r;

endmodule

/* rtl/core/circle_trajectory_imu_gen.sv */
// Top level of the circular trajectory IMU generator: config registers,
// phase pipeline, CORDIC, and the position/velocity/force pipeline.
// Depends on ctig_pkg and ctig_cordic.
//
//   channel | direction | handshake              | payload
//   in_     | input     | in_valid / in_stall    | time_stamp
//   out_    | output    | out_valid / out_stall  | pos, vel, acc, heading, body force/rate
//   cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One item per cycle sustained while no stall holds the output; 29 register stages lie
// from accept to out_valid: 5 phase, 16 CORDIC, 8 product/saturate.
// Reset (synchronous, rst_n low) clears all valid bits and loads the
// register defaults. A stall on the output while out_valid is high freezes
// the whole pipeline, and in_stall is high for exactly that cycle.

`timescale 1ns / 1ps

module circle_trajectory_imu_gen #(
  parameter int FRAC_BITS = ctig_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_time_stamp,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [31:0] out_pos_y,
  output logic signed [31:0] out_vel_x,
  output logic signed [31:0] out_vel_y,
  output logic signed [31:0] out_acc_x,
  output logic signed [31:0] out_acc_y,
  output logic        [31:0] out_heading,
  output logic signed [31:0] out_body_acc_x,
  output logic signed [31:0] out_body_acc_y,
  output logic signed [31:0] out_body_acc_z,
  output logic signed [31:0] out_body_rate_z,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // ---------------- configuration ----------------
  logic [31:0] phase_start_r, heading_start_r, turn_rate_r, radius_r;
  logic [31:0] gravity_x_r, gravity_y_r, gravity_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_start_r   <= '0;
      heading_start_r <= '0;
      turn_rate_r     <= '0;
      radius_r        <= ctig_pkg::RADIUS_RESET;
      gravity_x_r     <= '0;
      gravity_y_r     <= '0;
      gravity_z_r     <= ctig_pkg::GRAVITY_Z_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ctig_pkg::REG_PHASE_START:   phase_start_r   <= cfg_data;
        ctig_pkg::REG_HEADING_START: heading_start_r <= cfg_data;
        ctig_pkg::REG_TURN_RATE:     turn_rate_r     <= cfg_data;
        ctig_pkg::REG_RADIUS:        radius_r        <= cfg_data;
        ctig_pkg::REG_GRAVITY_X:     gravity_x_r     <= cfg_data;
        ctig_pkg::REG_GRAVITY_Y:     gravity_y_r     <= cfg_data;
        ctig_pkg::REG_GRAVITY_Z:     gravity_z_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // values derived from config; settle long before an item reaches them
  logic               wneg;
  logic [31:0]        wmag_r;
  logic signed [63:0] rw_r;
  logic [62:0]        rwm_r;
  logic               rwneg_r;
  logic signed [64:0] rw_full;

  assign wneg    = turn_rate_r[31];
  assign rw_full = signed'({1'b0, radius_r}) * signed'(turn_rate_r);

  always_ff @(posedge clk) begin
    wmag_r  <= wneg ? 32'd0 - turn_rate_r : turn_rate_r;
    rw_r    <= rw_full[63:0];
    rwneg_r <= rw_r[63];
    rwm_r   <= rw_r[63] ? 63'(64'd0 - rw_r) : rw_r[62:0];
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  logic v5_r, v6_r, v7_r, v8_r, v9_r, v10_r, v11_r, v12_r;
  logic cv;

  assign en       = !(v12_r && out_stall);
  assign in_stall = !en;

  // ---------------- phase stages ----------------
  logic [31:0] t0_r, t1_r;
  logic [61:0] mag1_r;
  logic [63:0] plo2_r;
  logic [61:0] phi2_r;
  logic [31:0] d3_r;
  logic [62:0] sum3;
  logic [31:0] dsg;
  logic [31:0] theta4_r, yaw4_r;

  assign sum3 = {1'b0, phi2_r} + {31'd0, plo2_r[63:32]};
  assign dsg  = wneg ? 32'd0 - d3_r : d3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t0_r     <= in_time_stamp;
      t1_r     <= t0_r;
      mag1_r   <= wmag_r * ctig_pkg::TURN_PER_RAD_Q32;
      plo2_r   <= mag1_r[31:0] * t1_r;
      phi2_r   <= mag1_r[61:32] * t1_r;
      d3_r     <= sum3[FRAC_BITS-8 +: 32];
      theta4_r <= phase_start_r + dsg;
      yaw4_r   <= heading_start_r + dsg;
    end
  end

  // ---------------- CORDIC ----------------
  logic [31:0] c_w, s_w, cy_w, sy_w, yaw_w;

  ctig_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v4_r),
    .in_theta (theta4_r),
    .in_yaw   (yaw4_r),
    .out_vld  (cv),
    .out_c    (c_w),
    .out_s    (s_w),
    .out_cy   (cy_w),
    .out_sy   (sy_w),
    .out_yaw  (yaw_w)
  );

  // ---------------- stage 5: magnitudes ----------------
  logic [30:0] cm5_r, sm5_r, cym5_r, sym5_r;
  logic        cn5_r, sn5_r, cyn5_r, syn5_r;
  logic [31:0] yaw5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cn5_r  <= c_w[31];
      sn5_r  <= s_w[31];
      cyn5_r <= cy_w[31];
      syn5_r <= sy_w[31];
      cm5_r  <= c_w[31]  ? 31'(32'd0 - c_w)  : c_w[30:0];
      sm5_r  <= s_w[31]  ? 31'(32'd0 - s_w)  : s_w[30:0];
      cym5_r <= cy_w[31] ? 31'(32'd0 - cy_w) : cy_w[30:0];
      sym5_r <= sy_w[31] ? 31'(32'd0 - sy_w) : sy_w[30:0];
      yaw5_r <= yaw_w;
    end
  end

  // ---------------- stage 6: radius products ----------------
  logic [62:0] prc6_r, prs6_r, vlc6_r, vls6_r;
  logic [61:0] vhc6_r, vhs6_r;
  logic        cn6_r, sn6_r, cyn6_r, syn6_r;
  logic [30:0] cym6_r, sym6_r;
  logic [31:0] yaw6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prc6_r <= radius_r * cm5_r;
      prs6_r <= radius_r * sm5_r;
      vlc6_r <= rwm_r[31:0] * cm5_r;
      vls6_r <= rwm_r[31:0] * sm5_r;
      vhc6_r <= rwm_r[62:32] * cm5_r;
      vhs6_r <= rwm_r[62:32] * sm5_r;
      cn6_r  <= cn5_r;
      sn6_r  <= sn5_r;
      cyn6_r <= cyn5_r;
      syn6_r <= syn5_r;
      cym6_r <= cym5_r;
      sym6_r <= sym5_r;
      yaw6_r <= yaw5_r;
    end
  end

  // ---------------- stage 7: position, velocity, first acc product ----------
  logic [94:0] fc6, fs6;
  logic [31:0] px7_r, py7_r, vx7_r, vy7_r;
  logic [62:0] m1c7_r, m1s7_r;
  logic        m1cn7_r, m1sn7_r;
  logic        cyn7_r, syn7_r;
  logic [30:0] cym7_r, sym7_r;
  logic [31:0] yaw7_r;

  assign fc6 = {1'b0, vhc6_r, 32'd0} + {32'd0, vlc6_r};
  assign fs6 = {1'b0, vhs6_r, 32'd0} + {32'd0, vls6_r};

  always_ff @(posedge clk) begin
    if (en) begin
      px7_r   <= ctig_pkg::sat_mag({31'd0, prc6_r[62:30]}, cn6_r);
      py7_r   <= ctig_pkg::sat_mag({31'd0, prs6_r[62:30]}, sn6_r);
      vx7_r   <= ctig_pkg::sat_mag({24'd0, fs6[93:54]}, !(rwneg_r ^ sn6_r));
      vy7_r   <= ctig_pkg::sat_mag({24'd0, fc6[93:54]}, rwneg_r ^ cn6_r);
      m1c7_r  <= fc6[92:30];
      m1s7_r  <= fs6[92:30];
      m1cn7_r <= rwneg_r ^ cn6_r;
      m1sn7_r <= rwneg_r ^ sn6_r;
      cyn7_r  <= cyn6_r;
      syn7_r  <= syn6_r;
      cym7_r  <= cym6_r;
      sym7_r  <= sym6_r;
      yaw7_r  <= yaw6_r;
    end
  end

  // ---------------- stage 8: acc times rate ----------------
  logic [63:0] alc8_r, als8_r;
  logic [62:0] ahc8_r, ahs8_r;
  logic        m1cn8_r, m1sn8_r;
  logic [31:0] px8_r, py8_r, vx8_r, vy8_r;
  logic        cyn8_r, syn8_r;
  logic [30:0] cym8_r, sym8_r;
  logic [31:0] yaw8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      alc8_r  <= m1c7_r[31:0] * wmag_r;
      als8_r  <= m1s7_r[31:0] * wmag_r;
      ahc8_r  <= m1c7_r[62:32] * wmag_r;
      ahs8_r  <= m1s7_r[62:32] * wmag_r;
      m1cn8_r <= m1cn7_r;
      m1sn8_r <= m1sn7_r;
      px8_r   <= px7_r;
      py8_r   <= py7_r;
      vx8_r   <= vx7_r;
      vy8_r   <= vy7_r;
      cyn8_r  <= cyn7_r;
      syn8_r  <= syn7_r;
      cym8_r  <= cym7_r;
      sym8_r  <= sym7_r;
      yaw8_r  <= yaw7_r;
    end
  end

  // ---------------- stage 9: world acceleration ----------------
  logic [95:0] fac8, fas8;
  logic [31:0] ax9_r, ay9_r;
  logic [31:0] px9_r, py9_r, vx9_r, vy9_r;
  logic        cyn9_r, syn9_r;
  logic [30:0] cym9_r, sym9_r;
  logic [31:0] yaw9_r;

  assign fac8 = {1'b0, ahc8_r, 32'd0} + {32'd0, alc8_r};
  assign fas8 = {1'b0, ahs8_r, 32'd0} + {32'd0, als8_r};

  always_ff @(posedge clk) begin
    if (en) begin
      ax9_r  <= ctig_pkg::sat_mag({16'd0, fac8[95:48]}, !(m1cn8_r ^ wneg));
      ay9_r  <= ctig_pkg::sat_mag({16'd0, fas8[95:48]}, !(m1sn8_r ^ wneg));
      px9_r  <= px8_r;
      py9_r  <= py8_r;
      vx9_r  <= vx8_r;
      vy9_r  <= vy8_r;
      cyn9_r <= cyn8_r;
      syn9_r <= syn8_r;
      cym9_r <= cym8_r;
      sym9_r <= sym8_r;
      yaw9_r <= yaw8_r;
    end
  end

  // ---------------- stage 10: acceleration plus gravity ----------------
  logic signed [32:0] fx9, fy9;
  logic [32:0] fxm10_r, fym10_r;
  logic        fxn10_r, fyn10_r;
  logic [31:0] ax10_r, ay10_r, px10_r, py10_r, vx10_r, vy10_r;
  logic        cyn10_r, syn10_r;
  logic [30:0] cym10_r, sym10_r;
  logic [31:0] yaw10_r;

  assign fx9 = 33'(signed'(ax9_r)) + 33'(signed'(gravity_x_r));
  assign fy9 = 33'(signed'(ay9_r)) + 33'(signed'(gravity_y_r));

  always_ff @(posedge clk) begin
    if (en) begin
      fxn10_r <= fx9[32];
      fyn10_r <= fy9[32];
      fxm10_r <= fx9[32] ? 33'd0 - fx9 : fx9;
      fym10_r <= fy9[32] ? 33'd0 - fy9 : fy9;
      ax10_r  <= ax9_r;
      ay10_r  <= ay9_r;
      px10_r  <= px9_r;
      py10_r  <= py9_r;
      vx10_r  <= vx9_r;
      vy10_r  <= vy9_r;
      cyn10_r <= cyn9_r;
      syn10_r <= syn9_r;
      cym10_r <= cym9_r;
      sym10_r <= sym9_r;
      yaw10_r <= yaw9_r;
    end
  end

  // ---------------- stage 11: rotation products ----------------
  logic [63:0] pxc11_r, pys11_r, pyc11_r, pxs11_r;
  logic        nxc11_r, nys11_r, nyc11_r, nxs11_r;
  logic [31:0] ax11_r, ay11_r, px11_r, py11_r, vx11_r, vy11_r, yaw11_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pxc11_r <= fxm10_r * cym10_r;
      pys11_r <= fym10_r * sym10_r;
      pyc11_r <= fym10_r * cym10_r;
      pxs11_r <= fxm10_r * sym10_r;
      nxc11_r <= fxn10_r ^ cyn10_r;
      nys11_r <= fyn10_r ^ syn10_r;
      nyc11_r <= fyn10_r ^ cyn10_r;
      nxs11_r <= fxn10_r ^ syn10_r;
      ax11_r  <= ax10_r;
      ay11_r  <= ay10_r;
      px11_r  <= px10_r;
      py11_r  <= py10_r;
      vx11_r  <= vx10_r;
      vy11_r  <= vy10_r;
      yaw11_r <= yaw10_r;
    end
  end

  // ---------------- stage 12: body force, output register ----------------
  function automatic logic signed [36:0] term(input logic [63:0] p, input logic neg);
    logic signed [36:0] m;
    m = signed'({3'd0, p[63:30]});
    return neg ? -m : m;
  endfunction

  logic signed [36:0] bx11, by11;
  logic [31:0] bx12_r, by12_r, ax12_r, ay12_r, px12_r, py12_r, vx12_r, vy12_r, yaw12_r;

  assign bx11 = term(pxc11_r, nxc11_r) + term(pys11_r, nys11_r);
  assign by11 = term(pyc11_r, nyc11_r) - term(pxs11_r, nxs11_r);

  always_ff @(posedge clk) begin
    if (en) begin
      bx12_r  <= ctig_pkg::sat_s37(bx11);
      by12_r  <= ctig_pkg::sat_s37(by11);
      ax12_r  <= ax11_r;
      ay12_r  <= ay11_r;
      px12_r  <= px11_r;
      py12_r  <= py11_r;
      vx12_r  <= vx11_r;
      vy12_r  <= vy11_r;
      yaw12_r <= yaw11_r;
    end
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v0_r, v1_r, v2_r, v3_r, v4_r}          <= '0;
      {v5_r, v6_r, v7_r, v8_r}                <= '0;
      {v9_r, v10_r, v11_r, v12_r}             <= '0;
    end else if (en) begin
      v0_r  <= in_valid;
      v1_r  <= v0_r;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= cv;
      v6_r  <= v5_r;
      v7_r  <= v6_r;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
      v11_r <= v10_r;
      v12_r <= v11_r;
    end
  end

  assign out_valid       = v12_r;
  assign out_pos_x       = px12_r;
  assign out_pos_y       = py12_r;
  assign out_vel_x       = vx12_r;
  assign out_vel_y       = vy12_r;
  assign out_acc_x       = ax12_r;
  assign out_acc_y       = ay12_r;
  assign out_heading     = yaw12_r;
  assign out_body_acc_x  = bx12_r;
  assign out_body_acc_y  = by12_r;
  assign out_body_acc_z  = gravity_z_r;
  assign out_body_rate_z = turn_rate_r;

endmodule

/* rtl/core/ctig_checker.sv */
// Port-level checker for circle_trajectory_imu_gen, attached by bind.
// Depends on ctig_pkg.
`timescale 1ns / 1ps

module ctig_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_pos_x,
  input logic [31:0] out_body_rate_z,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [31:0] cfg_data
);

  // input is held off exactly when a finished item waits
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow output backpressure");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled item dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pos_x))
    else $error("stalled payload changed");

  a_rate_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && cfg_valid && cfg_ready && cfg_index == ctig_pkg::REG_TURN_RATE
      |=> out_body_rate_z == $past(cfg_data))
    else $error("body rate does not reflect turn rate write");

endmodule

bind circle_trajectory_imu_gen ctig_checker u_ctig_checker (.*);
